>>> rtl/core/ptq_pkg.sv
// ptq_pkg: shared types, widths, register indexes and reset values
// for the proximity trigger qualifier. No dependencies.
package ptq_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int DIST_W       = 16;
  localparam int TIME_W       = 32;
  localparam int RUN_W        = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CHNUM_W      = 3;

  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER_THRESHOLDS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_THRESHOLDS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL_MS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_STABLE_COUNT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_STABLE_COUNT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TRIGGER_GAP_MS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT         = 4'd7;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              read_ok;
    logic [DIST_W-1:0] distance_mm;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               trigger;
    logic               rearm;
    logic               recover_request;
    logic [CHNUM_W-1:0] channel_number;
    logic [DIST_W-1:0]  trigger_distance;
    logic               is_near;
  } result_t;

  typedef struct packed {
    logic [3:0]  channel_enable;
    logic [63:0] enter_thresholds;
    logic [63:0] exit_thresholds;
    logic [15:0] read_interval_ms;
    logic [7:0]  near_stable_count;
    logic [7:0]  far_stable_count;
    logic [15:0] min_trigger_gap_ms;
    logic [7:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_read_time;
    logic [RUN_W-1:0]  fail_streak;
    logic              near_flag;
    logic [RUN_W-1:0]  near_run;
    logic [RUN_W-1:0]  far_run;
    logic              armed_flag;
    logic [TIME_W-1:0] last_trigger_time;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    last_read_time:    '0,
    fail_streak:       '0,
    near_flag:         1'b0,
    near_run:          '0,
    far_run:           '0,
    armed_flag:        1'b1,
    last_trigger_time: '0
  };

  localparam cfg_t CFG_RESET = '{
    channel_enable:     4'd15,
    enter_thresholds:   64'd0,
    exit_thresholds:    64'd0,
    read_interval_ms:   16'd20,
    near_stable_count:  8'd2,
    far_stable_count:   8'd3,
    min_trigger_gap_ms: 16'd100,
    fail_limit:         8'd5
  };

endpackage

>>> rtl/core/ptq_if.sv
// ptq_if: valid/ready channel interfaces for readings, results and
// configuration writes. Depends on ptq_pkg.
interface ptq_item_if;
  logic           valid;
  logic           ready;
  ptq_pkg::item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface ptq_result_if;
  logic             valid;
  logic             ready;
  ptq_pkg::result_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface ptq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ptq_pkg::CFG_IDX_W-1:0]  index;
  logic [ptq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ptq_cfg_regs.sv
// ptq_cfg_regs: configuration register file written over the cfg channel.
// Depends on ptq_pkg and ptq_if.
module ptq_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ptq_cfg_if.sink       cfg,
  output ptq_pkg::cfg_t regs
);

  ptq_pkg::cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      // indexes beyond the list are dropped
      unique case (cfg.index)
        ptq_pkg::REG_CHANNEL_ENABLE:     regs_next.channel_enable     = cfg.data[3:0];
        ptq_pkg::REG_ENTER_THRESHOLDS:   regs_next.enter_thresholds   = cfg.data;
        ptq_pkg::REG_EXIT_THRESHOLDS:    regs_next.exit_thresholds    = cfg.data;
        ptq_pkg::REG_READ_INTERVAL_MS:   regs_next.read_interval_ms   = cfg.data[15:0];
        ptq_pkg::REG_NEAR_STABLE_COUNT:  regs_next.near_stable_count  = cfg.data[7:0];
        ptq_pkg::REG_FAR_STABLE_COUNT:   regs_next.far_stable_count   = cfg.data[7:0];
        ptq_pkg::REG_MIN_TRIGGER_GAP_MS: regs_next.min_trigger_gap_ms = cfg.data[15:0];
        ptq_pkg::REG_FAIL_LIMIT:         regs_next.fail_limit         = cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= ptq_pkg::CFG_RESET;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

>>> rtl/core/ptq_chan_update.sv
// ptq_chan_update: per-reading qualification logic, from one channel's
// state and one reading to the new state and the result. Depends on ptq_pkg.
module ptq_chan_update (
  input  ptq_pkg::item_t       item,
  input  ptq_pkg::cfg_t        cfg,
  input  ptq_pkg::chan_state_t cur,
  output ptq_pkg::chan_state_t nxt,
  output logic                 write,
  output ptq_pkg::result_t     res
);

  logic                             in_range;
  logic [ptq_pkg::TIME_W-1:0]      read_gap;
  logic [ptq_pkg::TIME_W-1:0]      trig_gap;
  logic [ptq_pkg::DIST_W-1:0]      enter_thr;
  logic [ptq_pkg::DIST_W-1:0]      exit_thr;
  logic [ptq_pkg::RUN_W-1:0]       streak_inc;
  logic                             near;
  logic                             enter_near;
  logic                             leave_near;
  logic                             fire;

  assign in_range  = {1'b0, item.channel} < (ptq_pkg::CH_W + 1)'(ptq_pkg::NUM_CHANNELS);
  assign read_gap  = item.time_ms - cur.last_read_time;
  assign trig_gap  = item.time_ms - cur.last_trigger_time;
  assign enter_thr = cfg.enter_thresholds[item.channel * ptq_pkg::DIST_W +: ptq_pkg::DIST_W];
  assign exit_thr  = cfg.exit_thresholds[item.channel * ptq_pkg::DIST_W +: ptq_pkg::DIST_W];
  assign streak_inc = (cur.fail_streak < ptq_pkg::RUN_MAX) ? cur.fail_streak + 1'b1
                                                           : cur.fail_streak;
  assign near = cur.near_flag ? (item.distance_mm <= exit_thr)
                              : (item.distance_mm <= enter_thr);

  assign write = in_range && cfg.channel_enable[item.channel] &&
                 (read_gap >= ptq_pkg::TIME_W'(cfg.read_interval_ms));

  always_comb begin
    nxt        = cur;
    res        = '0;
    enter_near = 1'b0;
    leave_near = 1'b0;
    fire       = 1'b0;
    if (write) begin
      nxt.last_read_time = item.time_ms;
      if (!item.read_ok) begin
        nxt.fail_streak = streak_inc;
        if (streak_inc >= cfg.fail_limit) begin
          nxt.fail_streak     = '0;
          res.recover_request = 1'b1;
        end
      end else begin
        nxt.fail_streak = '0;
        if (near) begin
          if (cur.near_run < ptq_pkg::RUN_MAX) nxt.near_run = cur.near_run + 1'b1;
          nxt.far_run = '0;
        end else begin
          if (cur.far_run < ptq_pkg::RUN_MAX) nxt.far_run = cur.far_run + 1'b1;
          nxt.near_run = '0;
        end
        // entering and leaving near exclude each other: one needs near, one far
        enter_near = !cur.near_flag && near && (nxt.near_run >= cfg.near_stable_count);
        leave_near = cur.near_flag && !near && (nxt.far_run >= cfg.far_stable_count);
        fire = enter_near && cur.armed_flag &&
               (trig_gap >= ptq_pkg::TIME_W'(cfg.min_trigger_gap_ms));
        if (enter_near) nxt.near_flag = 1'b1;
        if (fire) begin
          nxt.last_trigger_time = item.time_ms;
          nxt.armed_flag        = 1'b0;
        end
        if (leave_near) begin
          nxt.near_flag  = 1'b0;
          nxt.armed_flag = 1'b1;
        end
      end
    end
    res.accepted = write;
    res.trigger  = fire;
    res.rearm    = leave_near;
    if (fire) begin
      res.channel_number   = ptq_pkg::CHNUM_W'(item.channel) + 1'b1;
      res.trigger_distance = item.distance_mm;
    end
    res.is_near = in_range && nxt.near_flag;
  end

endmodule

>>> rtl/core/proximity_trigger_qualifier_core.sv
// proximity_trigger_qualifier_core: an accepted reading passes the input
// register, then one pass of qualification logic into the result register.
// Throughput one reading per cycle while result.ready is not held low; the
// per-channel state is read and written in the same cycle, so back-to-back
// readings on one channel see each other. Synchronous active-high reset
// restores the register defaults and the per-channel state; no clearing pass.
module proximity_trigger_qualifier_core (
  input  logic       clk,
  input  logic       rst,
  ptq_item_if.sink   item,
  ptq_result_if.source result,
  ptq_cfg_if.sink    cfg
);

  ptq_pkg::cfg_t        regs;
  logic                 s1_valid;
  ptq_pkg::item_t       s1_item;
  logic                 s1_adv;
  logic                 out_valid;
  ptq_pkg::result_t     out_data;
  ptq_pkg::chan_state_t state [ptq_pkg::NUM_CHANNELS];
  ptq_pkg::chan_state_t cur_state;
  ptq_pkg::chan_state_t upd_state;
  logic                 upd_write;
  ptq_pkg::result_t     upd_res;

  ptq_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // reading moves on when the result register is free or being drained
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign cur_state  = state[s1_item.channel];

  ptq_chan_update u_upd (
    .item  (s1_item),
    .cfg   (regs),
    .cur   (cur_state),
    .nxt   (upd_state),
    .write (upd_write),
    .res   (upd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= upd_res;
    end
  end

  for (genvar i = 0; i < ptq_pkg::NUM_CHANNELS; i++) begin : g_chan
    always_ff @(posedge clk) begin
      if (rst) begin
        state[i] <= ptq_pkg::CHAN_RESET;
      end else if (s1_adv && upd_write && (s1_item.channel == ptq_pkg::CH_W'(i))) begin
        state[i] <= upd_state;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

>>> rtl/core/ptq_checker.sv
// ptq_checker: port-level assertions for the proximity trigger qualifier,
// bound to the top level. Depends on ptq_pkg.
module ptq_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input ptq_pkg::result_t res_data
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // a trigger only on an accepted reading that ends near, with its channel tag
  a_trig_near: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.trigger |->
      res_data.accepted && res_data.is_near && (res_data.channel_number != '0))
    else $error("trigger without accepted near reading");

  // no trigger means no channel tag and no distance
  a_trig_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.trigger |->
      (res_data.channel_number == '0) && (res_data.trigger_distance == '0))
    else $error("trigger fields set without trigger");

  // rearm leaves the channel far and excludes a trigger
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.rearm |->
      res_data.accepted && !res_data.is_near && !res_data.trigger)
    else $error("inconsistent rearm beat");

  // recovery comes from a failed read, which never touches near/far logic
  a_recover: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.recover_request |->
      res_data.accepted && !res_data.trigger && !res_data.rearm)
    else $error("inconsistent recovery beat");

endmodule

bind proximity_trigger_qualifier_core ptq_checker u_ptq_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
